>>> design/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg: shared types and constants of the multidrop frame receiver
// Result codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package mfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int OUT_BYTES = 8;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		KIND_HOUSE = 2'd0,
		KIND_ECHO  = 2'd1,
		KIND_LOBBY = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_END_BYTE   = 3'd0,
		REG_ECHO_CMD   = 3'd1,
		REG_BYTE_GAP   = 3'd2,
		REG_FRAME_GAP  = 3'd3,
		REG_NODE_ID    = 3'd4,
		REG_MASTER_ID  = 3'd5
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] TOP_BIT   = 8'h80;
	localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7F;
	localparam logic [BYTE_W-1:0] NODE_MASK = 8'h3F;
	localparam logic [BYTE_W-1:0] GAP_MAX   = 8'hFF;

	localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd3;
	localparam logic [BYTE_W-1:0] ECHO_CMD_RST   = 8'd0;
	localparam logic [BYTE_W-1:0] BYTE_GAP_RST   = 8'd10;
	localparam logic [BYTE_W-1:0] FRAME_GAP_RST  = 8'd20;
	localparam logic [BYTE_W-1:0] NODE_ID_RST    = 8'd0;
	localparam logic [BYTE_W-1:0] MASTER_ID_RST  = 8'd1;

	typedef struct packed {
		kind_t                           kind;
		logic [OUT_BYTES-1:0][BYTE_W-1:0] bytes;
	} result_t;

endpackage

>>> design/multidrop_frame_receiver.sv
// ----------------------------------------------------------------------------
// multidrop_frame_receiver
// Frame assembly and filtering for a 9-bit multidrop serial line.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one received character with its
// address flag and line error flag, or a 1 ms tick (mode = 1).
// Output channel (out_valid / out_stall): one frame record per completed and
// accepted frame (house, echo or lobby), or an error record for a character
// with a line error. Ticks, address bytes and plain data bytes give nothing.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index.
// Throughput: one input transfer per cycle while in_stall is low. The character
// is decoded against the frame state in the cycle it is taken; its result is
// registered in the output register, or in the skid register if that one is held.
// A one-entry skid register behind the output register keeps input taken
// while one result waits; in_stall rises only when both are full.
// Reset: awaiting an address byte, gap timer zero, registers at their
// defaults, no result pending.
// ----------------------------------------------------------------------------
module multidrop_frame_receiver #(
	parameter int LONG_FRAME_BYTES  = 8,
	parameter int SHORT_FRAME_BYTES = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [mfr_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         address_bit,
	input  logic                         line_error,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   kind,
	output logic [mfr_pkg::BYTE_W-1:0]   byte_0,
	output logic [mfr_pkg::BYTE_W-1:0]   byte_1,
	output logic [mfr_pkg::BYTE_W-1:0]   byte_2,
	output logic [mfr_pkg::BYTE_W-1:0]   byte_3,
	output logic [mfr_pkg::BYTE_W-1:0]   byte_4,
	output logic [mfr_pkg::BYTE_W-1:0]   byte_5,
	output logic [mfr_pkg::BYTE_W-1:0]   byte_6,
	output logic [mfr_pkg::BYTE_W-1:0]   byte_7,
	input  logic                         cfg_we,
	input  logic [mfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfr_pkg::BYTE_W-1:0]   cfg_wdata
);
	import mfr_pkg::*;

	localparam int IW   = $clog2(LONG_FRAME_BYTES + 1);
	localparam int SW   = $clog2(LONG_FRAME_BYTES);
	localparam int VIEW = (LONG_FRAME_BYTES > OUT_BYTES) ? LONG_FRAME_BYTES : OUT_BYTES;
	localparam logic [IW-1:0] SHORT_LAST = IW'(SHORT_FRAME_BYTES - 1);
	localparam logic [IW-1:0] LONG_LAST  = IW'(LONG_FRAME_BYTES - 1);

	logic [BYTE_W-1:0] end_byte_q, echo_cmd_q, byte_gap_q, frame_gap_q;
	logic [BYTE_W-1:0] node_id_q, master_id_q;

	logic [IW-1:0]     byte_index_q, byte_index_d;
	logic [BYTE_W-1:0] gap_timer_q, gap_timer_d;
	logic              addr_mode_q, addr_mode_d;
	logic [BYTE_W-1:0] store_q [LONG_FRAME_BYTES];

	logic              accept;
	logic              store_we;
	logic [SW-1:0]     store_addr;
	logic [IW-1:0]     idx_inc;
	logic [BYTE_W-1:0] store_view [VIEW];
	logic [BYTE_W:0]   frame_gap_sum;
	logic [BYTE_W-1:0] frame_gap_load;
	logic              res_valid;
	result_t           res;
	int                res_len;
	logic              clear_top;

	logic              out_valid_q, skid_valid_q, pop;
	result_t           out_q, skid_q;

	assign accept   = in_valid && !in_stall;
	assign in_stall = skid_valid_q;
	assign idx_inc  = byte_index_q + IW'(1);

	assign frame_gap_sum  = {1'b0, frame_gap_q} + {1'b0, node_id_q & NODE_MASK};
	assign frame_gap_load = frame_gap_sum[BYTE_W] ? GAP_MAX : frame_gap_sum[BYTE_W-1:0];

	// store contents as seen after this character is written
	always_comb begin
		for (int i = 0; i < VIEW; i++) begin
			if (i < LONG_FRAME_BYTES) begin
				store_view[i] = store_q[i];
				if (IW'(i) == idx_inc) begin
					store_view[i] = data_byte;
				end
			end else begin
				store_view[i] = '0;
			end
		end
	end

	always_comb begin
		byte_index_d = byte_index_q;
		gap_timer_d  = gap_timer_q;
		addr_mode_d  = addr_mode_q;
		store_we     = 1'b0;
		store_addr   = '0;
		res_valid    = 1'b0;
		res_len      = 0;
		clear_top    = 1'b1;
		res.kind     = KIND_ERROR;
		if (mode) begin
			if (gap_timer_q != '0) begin
				gap_timer_d = gap_timer_q - BYTE_W'(1);
			end
		end else if (line_error) begin
			res_valid = 1'b1;
		end else if (address_bit) begin
			addr_mode_d  = 1'b0;
			byte_index_d = '0;
			store_we     = 1'b1;
			store_addr   = '0;
			gap_timer_d  = byte_gap_q;
		end else if (!addr_mode_q) begin
			byte_index_d = idx_inc;
			store_we     = (idx_inc < IW'(LONG_FRAME_BYTES));
			store_addr   = idx_inc[SW-1:0];
			if (gap_timer_q == '0) begin
				byte_index_d = '0;
				addr_mode_d  = 1'b1;
			end else begin
				gap_timer_d = byte_gap_q;
				if (idx_inc == SHORT_LAST && data_byte == end_byte_q) begin
					gap_timer_d = frame_gap_load;
					addr_mode_d = 1'b1;
					res_valid   = store_view[0][BYTE_W-1];
					res_len     = SHORT_FRAME_BYTES;
					if (store_view[1] == echo_cmd_q) begin
						res.kind  = KIND_ECHO;
						clear_top = 1'b0;
					end else begin
						res.kind  = KIND_HOUSE;
					end
				end else if (idx_inc == LONG_LAST && data_byte == end_byte_q) begin
					gap_timer_d = frame_gap_load;
					addr_mode_d = 1'b1;
					res_len     = LONG_FRAME_BYTES;
					res.kind    = KIND_LOBBY;
					if (node_id_q == master_id_q) begin
						res_valid = store_view[0][BYTE_W-1];
					end else begin
						res_valid = !store_view[0][BYTE_W-1];
					end
				end else if (idx_inc > LONG_LAST) begin
					byte_index_d = '0;
					addr_mode_d  = 1'b1;
				end
			end
		end
		for (int i = 0; i < OUT_BYTES; i++) begin
			res.bytes[i] = (i < res_len) ? store_view[i] : '0;
		end
		if (clear_top) begin
			res.bytes[0] = res.bytes[0] & LOW7_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_byte_q  <= END_BYTE_RST;
			echo_cmd_q  <= ECHO_CMD_RST;
			byte_gap_q  <= BYTE_GAP_RST;
			frame_gap_q <= FRAME_GAP_RST;
			node_id_q   <= NODE_ID_RST;
			master_id_q <= MASTER_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_END_BYTE:  end_byte_q  <= cfg_wdata;
				REG_ECHO_CMD:  echo_cmd_q  <= cfg_wdata;
				REG_BYTE_GAP:  byte_gap_q  <= cfg_wdata;
				REG_FRAME_GAP: frame_gap_q <= cfg_wdata;
				REG_NODE_ID:   node_id_q   <= cfg_wdata;
				REG_MASTER_ID: master_id_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			gap_timer_q  <= '0;
			addr_mode_q  <= 1'b1;
		end else if (accept) begin
			byte_index_q <= byte_index_d;
			gap_timer_q  <= gap_timer_d;
			addr_mode_q  <= addr_mode_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_we) begin
			store_q[store_addr] <= data_byte;
		end
	end

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && res_valid) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (accept && res_valid) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign byte_0    = out_q.bytes[0];
	assign byte_1    = out_q.bytes[1];
	assign byte_2    = out_q.bytes[2];
	assign byte_3    = out_q.bytes[3];
	assign byte_4    = out_q.bytes[4];
	assign byte_5    = out_q.bytes[5];
	assign byte_6    = out_q.bytes[6];
	assign byte_7    = out_q.bytes[7];

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q < IW'(LONG_FRAME_BYTES))
		else $error("frame index past long frame length");

	a_error_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_ERROR) |-> (out_q.bytes == '0))
		else $error("line error record carries frame bytes");

	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode && !skid_valid_q && !out_valid_q) |=> !out_valid_q)
		else $error("tick produced a result");

endmodule
